// ===== sv/uvs_pkg.sv =====
// Shared types and constants for the unique value set.
// Used by the controller, the datapath and the top level; depends on nothing.
package uvs_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int ACTION_W = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int OUT_W    = 16;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} uvs_cmd_t;

endpackage

// ===== sv/unique_value_set.sv =====
// Top level of the unique value set: stream ports around controller and datapath.
// Depends on uvs_pkg, uvs_ctrl and uvs_datapath.
//
// A bounded set of up to CAPACITY distinct 32-bit keys kept in insertion order.
// Each input transfer carries an action in tuser (0 insert, 1 remove, 2 search)
// and a key in tdata, and yields exactly one result transfer with status, found,
// count and is_empty. In IDLE the key is compared against every stored entry in
// parallel as it is taken; in EXEC the store is updated (append, or shift down of
// the later entries on remove) and the result register loads. The next input
// is taken while a result waits; the update stalls only while the previous result
// is still held.
module unique_value_set import uvs_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [KEY_W-1:0]    s_axis_tdata,  // [31:0] key
	input  logic [ACTION_W-1:0] s_axis_tuser,  // [1:0] action
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata   // [2:0] status, [3] found, [8:4] count,
	                                           // [9] is_empty, [15:10] zero
);

	uvs_cmd_t            cmd;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	uvs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd)
	);

	uvs_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.action   (s_axis_tuser),
		.key      (s_axis_tdata),
		.status   (status),
		.found    (found),
		.count    (count),
		.is_empty (is_empty)
	);

	assign m_axis_tdata = {6'b0, is_empty, count, found, status};

endmodule

// ===== sv/uvs_ctrl.sv =====
// Controller for the unique value set: sequences capture and execute of one transfer.
// Depends on uvs_pkg.
module uvs_ctrl import uvs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	output logic     m_axis_tvalid,
	input  logic     m_axis_tready,
	output uvs_cmd_t cmd
);

	fsm_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		cmd.capture   = 1'b0;
		cmd.execute   = 1'b0;
		out_valid_d   = out_valid_q && !m_axis_tready;
		case (state_q)
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!out_valid_q || m_axis_tready) begin
					cmd.execute = 1'b1;
					out_valid_d = 1'b1;
					state_d     = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

// ===== sv/uvs_datapath.sv =====
// Datapath for the unique value set: key store, parallel compare, shift on remove,
// and the result register. Depends on uvs_pkg.
module uvs_datapath import uvs_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uvs_cmd_t            cmd,
	input  logic [ACTION_W-1:0] action,
	input  logic [KEY_W-1:0]    key,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [COUNT_W-1:0]  count,
	output logic                is_empty
);

	localparam int UW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]    entries_q [CAPACITY];
	logic [UW-1:0]       used_q;
	logic [ACTION_W-1:0] action_q;
	logic [KEY_W-1:0]    key_q;
	logic [CAPACITY-1:0] match_q;
	logic [CAPACITY-1:0] match_d;
	logic [CAPACITY-1:0] after;

	logic                hit;
	logic                do_insert;
	logic                do_remove;
	logic [UW-1:0]       used_d;
	logic [STATUS_W-1:0] status_d;
	logic [UW+COUNT_W-1:0] count_ext;

	genvar j;
	generate
		for (j = 0; j < CAPACITY; j++) begin : g_slot
			assign match_d[j] = (UW'(j) < used_q) && (entries_q[j] == key);
			assign after[j]   = |match_q[j:0];

			always_ff @(posedge clk) begin
				if (cmd.execute) begin
					if (do_insert && (used_q == UW'(j))) begin
						entries_q[j] <= key_q;
					end else if (do_remove && after[j]) begin
						if (j + 1 < CAPACITY) begin
							entries_q[j] <= entries_q[(j + 1) % CAPACITY];
						end
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			key_q    <= key;
			match_q  <= match_d;
		end
	end

	always_comb begin
		hit       = |match_q;
		do_insert = 1'b0;
		do_remove = 1'b0;
		used_d    = used_q;
		status_d  = ST_OK;
		case (action_q)
			ACT_INSERT: begin
				if (hit) begin
					status_d = ST_DUP;
				end else if (used_q >= UW'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					do_insert = 1'b1;
					used_d    = used_q + UW'(1);
				end
			end
			ACT_REMOVE: begin
				if (used_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!hit) begin
					status_d = ST_MISS;
				end else begin
					do_remove = 1'b1;
					used_d    = used_q - UW'(1);
				end
			end
			ACT_SEARCH: begin
				status_d = hit ? ST_OK : ST_MISS;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		count_ext = {{COUNT_W{1'b0}}, used_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.execute) begin
			used_q <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status   <= status_d;
			found    <= hit && (action_q <= ACT_SEARCH);
			count    <= count_ext[COUNT_W-1:0];
			is_empty <= (used_d == '0);
		end
	end

endmodule
